/* hdl/triangle_scanline_span_defines.svh */
// assertion macros shared by the span block
`ifndef TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_DEFINES_SVH

// same-cycle implication on clk, disabled during reset
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, disabled during reset
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tss_pkg.sv */
package tss_pkg;

    localparam int COORD_BITS  = 12;
    localparam int IN_FIELDS   = 7;
    localparam int DIV_STEP    = 3;
    localparam int DIV_STAGES  = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PIPE_DEPTH  = 3 + DIV_STAGES;
    localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vtx_t;

    typedef struct packed {
        vtx_t s;
        vtx_t e;
    } edge_t;

    // magnitudes for the unsigned divide plus the sign and fallback info
    typedef struct packed {
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COORD_BITS-1:0] mag;
        logic                  neg;
        logic                  horiz;
        coord_t                x0;
    } prep_t;

    typedef struct packed {
        logic   neg;
        logic   horiz;
        coord_t x0;
    } side_t;

endpackage

/* hdl/triangle_scanline_span.sv */
// throughput: one item per cycle when not stalled; sort, edge setup, multiply, one divider
//   stage per 3 quotient bits, and the output register each take one pipeline stage
// a stall on the output freezes the whole pipeline; nothing is dropped or repeated
// reset (rst_n, async, active low) clears the valid bits; no state carries between items
`include "triangle_scanline_span_defines.svh"

module triangle_scanline_span (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, scan_y, zero pad
    input  logic [tss_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // long_edge_x, short_edge_x
    output logic [tss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // in_range
    output logic                           m_axis_tuser
);
    import tss_pkg::*;

    logic                  ce;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  out_valid_reg;

    edge_t  long_reg;
    edge_t  long_next;
    edge_t  short_reg;
    edge_t  short_next;
    coord_t sy_reg;
    coord_t sy_next;
    logic   ok1_reg;
    logic   ok1_next;

    prep_t long_prep_reg;
    prep_t long_prep_next;
    prep_t short_prep_reg;
    prep_t short_prep_next;
    logic  ok2_reg;

    logic [2*COORD_BITS-1:0] long_prod_reg;
    logic [2*COORD_BITS-1:0] long_prod_next;
    logic [2*COORD_BITS-1:0] short_prod_reg;
    logic [2*COORD_BITS-1:0] short_prod_next;
    logic [COORD_BITS-1:0]   long_den_reg;
    logic [COORD_BITS-1:0]   short_den_reg;
    side_t                   long_side3_reg;
    side_t                   short_side3_reg;
    logic                    ok3_reg;

    side_t                 long_side_reg  [DIV_STAGES];
    side_t                 short_side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] ok_div_reg;

    logic [COORD_BITS-1:0]  long_quot;
    logic [COORD_BITS-1:0]  short_quot;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                   out_user_reg;

    function automatic prep_t prep_edge(input edge_t ed, input coord_t sy);
        logic [COORD_BITS:0] dy_scan;
        logic [COORD_BITS:0] dy_edge;
        logic [COORD_BITS:0] dx;
        logic [COORD_BITS:0] dx_abs;
        prep_t               p;
        dy_scan = {ed.s.y[COORD_BITS-1], ed.s.y} - {sy[COORD_BITS-1], sy};
        dy_edge = {ed.s.y[COORD_BITS-1], ed.s.y} - {ed.e.y[COORD_BITS-1], ed.e.y};
        dx      = {ed.e.x[COORD_BITS-1], ed.e.x} - {ed.s.x[COORD_BITS-1], ed.s.x};
        dx_abs  = dx[COORD_BITS] ? -dx : dx;
        p.a     = dy_scan[COORD_BITS-1:0];
        p.b     = dy_edge[COORD_BITS-1:0];
        p.mag   = dx_abs[COORD_BITS-1:0];
        p.neg   = dx[COORD_BITS];
        p.horiz = (ed.s.y == ed.e.y);
        p.x0    = ed.s.x;
        return p;
    endfunction

    function automatic logic [COORD_BITS-1:0] finish_x(input side_t sd,
                                                       input logic [COORD_BITS-1:0] q);
        logic [COORD_BITS:0] off;
        logic [COORD_BITS:0] sum;
        off = sd.neg ? -{1'b0, q} : {1'b0, q};
        sum = {sd.x0[COORD_BITS-1], sd.x0} + off;
        return sd.horiz ? sd.x0 : sum[COORD_BITS-1:0];
    endfunction

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;
    assign valid_next    = {valid_reg[PIPE_DEPTH-2:0], s_axis_tvalid};

    // stage 1: stable descending sort by y, edge selection, range check
    always_comb
    begin
        vtx_t   v0;
        vtx_t   v1;
        vtx_t   v2;
        vtx_t   hi;
        vtx_t   lo;
        vtx_t   top_v;
        vtx_t   mid_v;
        vtx_t   bot_v;
        coord_t sy;
        v0.x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
        v0.y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
        v1.x = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        v1.y = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        v2.x = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
        v2.y = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
        sy   = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
        if (v1.y > v0.y)
        begin
            hi = v1;
            lo = v0;
        end
        else
        begin
            hi = v0;
            lo = v1;
        end
        if (v2.y > lo.y)
        begin
            if (v2.y > hi.y)
            begin
                top_v = v2;
                mid_v = hi;
            end
            else
            begin
                top_v = hi;
                mid_v = v2;
            end
            bot_v = lo;
        end
        else
        begin
            top_v = hi;
            mid_v = lo;
            bot_v = v2;
        end
        ok1_next    = (sy <= top_v.y) && (sy >= bot_v.y);
        long_next.s = top_v;
        long_next.e = bot_v;
        if (sy > mid_v.y)
        begin
            short_next.s = top_v;
            short_next.e = mid_v;
        end
        else
        begin
            short_next.s = mid_v;
            short_next.e = bot_v;
        end
        sy_next = sy;
    end

    // stage 2: differences and magnitudes
    always_comb
    begin
        long_prep_next  = prep_edge(long_reg, sy_reg);
        short_prep_next = prep_edge(short_reg, sy_reg);
    end

    // stage 3: exact products
    assign long_prod_next  = long_prep_reg.a * long_prep_reg.mag;
    assign short_prod_next = short_prep_reg.a * short_prep_reg.mag;

    tss_divider u_long_div (
        .clk  (clk),
        .en   (ce),
        .num  (long_prod_reg),
        .den  (long_den_reg),
        .quot (long_quot)
    );

    tss_divider u_short_div (
        .clk  (clk),
        .en   (ce),
        .num  (short_prod_reg),
        .den  (short_den_reg),
        .quot (short_quot)
    );

    always_comb
    begin
        out_data_next = '0;
        if (ok_div_reg[DIV_STAGES-1])
        begin
            out_data_next[COORD_BITS-1:0] =
                finish_x(long_side_reg[DIV_STAGES-1], long_quot);
            out_data_next[2*COORD_BITS-1:COORD_BITS] =
                finish_x(short_side_reg[DIV_STAGES-1], short_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            long_reg       <= long_next;
            short_reg      <= short_next;
            sy_reg         <= sy_next;
            ok1_reg        <= ok1_next;

            long_prep_reg  <= long_prep_next;
            short_prep_reg <= short_prep_next;
            ok2_reg        <= ok1_reg;

            long_prod_reg  <= long_prod_next;
            short_prod_reg <= short_prod_next;
            long_den_reg   <= long_prep_reg.b;
            short_den_reg  <= short_prep_reg.b;
            long_side3_reg <= '{neg: long_prep_reg.neg, horiz: long_prep_reg.horiz,
                                x0: long_prep_reg.x0};
            short_side3_reg <= '{neg: short_prep_reg.neg, horiz: short_prep_reg.horiz,
                                 x0: short_prep_reg.x0};
            ok3_reg        <= ok2_reg;

            long_side_reg[0]  <= long_side3_reg;
            short_side_reg[0] <= short_side3_reg;
            ok_div_reg[0]     <= ok3_reg;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                long_side_reg[s]  <= long_side_reg[s-1];
                short_side_reg[s] <= short_side_reg[s-1];
                ok_div_reg[s]     <= ok_div_reg[s-1];
            end

            out_data_reg <= out_data_next;
            out_user_reg <= ok_div_reg[DIV_STAGES-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `TSS_ASSERT_NOW(a_out_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "nonzero x")
    `TSS_ASSERT_NEXT(a_last_moves, valid_reg[PIPE_DEPTH-1] && ce, m_axis_tvalid, "item lost")
    `TSS_ASSERT_NEXT(a_stall_hold, !s_axis_tready, $stable(valid_reg), "moved in stall")

endmodule

/* hdl/tss_divider.sv */
module tss_divider (
    input  logic                              clk,
    input  logic                              en,
    input  logic [2*tss_pkg::COORD_BITS-1:0] num,
    input  logic [tss_pkg::COORD_BITS-1:0]   den,
    output logic [tss_pkg::COORD_BITS-1:0]   quot
);
    import tss_pkg::*;

    logic [COORD_BITS-1:0] rem_reg  [DIV_STAGES];
    logic [COORD_BITS-1:0] low_reg  [DIV_STAGES];
    logic [COORD_BITS-1:0] quot_reg [DIV_STAGES];
    logic [COORD_BITS-1:0] den_reg  [DIV_STAGES];
    logic [COORD_BITS-1:0] rem_next  [DIV_STAGES];
    logic [COORD_BITS-1:0] low_next  [DIV_STAGES];
    logic [COORD_BITS-1:0] quot_next [DIV_STAGES];
    logic [COORD_BITS-1:0] den_next  [DIV_STAGES];

    // restoring division, DIV_STEP quotient bits per stage, msb first
    always_comb
    begin
        logic [COORD_BITS:0]   trial;
        logic [COORD_BITS:0]   diff;
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] l;
        logic [COORD_BITS-1:0] q;
        logic [COORD_BITS-1:0] d;
        trial = '0;
        diff  = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = num[2*COORD_BITS-1:COORD_BITS];
                l = num[COORD_BITS-1:0];
                q = '0;
                d = den;
            end
            else
            begin
                r = rem_reg[s-1];
                l = low_reg[s-1];
                q = quot_reg[s-1];
                d = den_reg[s-1];
            end
            for (int k = 0; k < DIV_STEP; k++)
            begin
                if (s * DIV_STEP + k < COORD_BITS)
                begin
                    trial = {r, l[COORD_BITS-1]};
                    diff  = trial - {1'b0, d};
                    l     = {l[COORD_BITS-2:0], 1'b0};
                    if (trial >= {1'b0, d})
                    begin
                        r = diff[COORD_BITS-1:0];
                        q = {q[COORD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        r = trial[COORD_BITS-1:0];
                        q = {q[COORD_BITS-2:0], 1'b0};
                    end
                end
            end
            rem_next[s]  = r;
            low_next[s]  = l;
            quot_next[s] = q;
            den_next[s]  = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                quot_reg[s] <= quot_next[s];
                den_reg[s]  <= den_next[s];
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];

endmodule

/* bench/triangle_scanline_span_tb.sv */
module triangle_scanline_span_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int CB = COORD_BITS;
    localparam longint COORD_HI = (longint'(1) << (CB - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct {
        coord_t long_x;
        coord_t short_x;
        logic   in_range;
    } span_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic calm = 1'b0;
    int error_count = 0;
    int quiet_cycles = 0;
    span_t expected_spans[$];

    triangle_scanline_span u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_HI)
            return coord_t'(COORD_HI);
        if (v < COORD_LO)
            return coord_t'(COORD_LO);
        return coord_t'(v);
    endfunction

    // x where row meets the edge s->e, start x on a flat edge
    function automatic longint edge_cross(input point_t s, input point_t e, input longint row);
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        sx = s.x;
        sy = s.y;
        ex = e.x;
        ey = e.y;
        if (sy == ey)
            return sx;
        return sx + ((row - sy) * (ex - sx)) / (ey - sy);
    endfunction

    function automatic span_t predict_span(input point_t a, input point_t b, input point_t c,
                                           input coord_t row);
        point_t v[3];
        point_t t;
        span_t r;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        // stable sort, highest y first
        if (v[1].y > v[0].y)
        begin
            t = v[0];
            v[0] = v[1];
            v[1] = t;
        end
        if (v[2].y > v[1].y)
        begin
            t = v[1];
            v[1] = v[2];
            v[2] = t;
        end
        if (v[1].y > v[0].y)
        begin
            t = v[0];
            v[0] = v[1];
            v[1] = t;
        end
        r.in_range = (row <= v[0].y) && (row >= v[2].y);
        r.long_x = '0;
        r.short_x = '0;
        if (r.in_range)
        begin
            r.long_x = clamp_coord(edge_cross(v[0], v[2], row));
            if (row > v[1].y)
                r.short_x = clamp_coord(edge_cross(v[0], v[1], row));
            else
                r.short_x = clamp_coord(edge_cross(v[1], v[2], row));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_span(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy, input int sy);
        point_t a;
        point_t b;
        point_t c;
        coord_t row;
        logic [IN_TDATA_W-1:0] word;
        a.x = coord_t'(ax);
        a.y = coord_t'(ay);
        b.x = coord_t'(bx);
        b.y = coord_t'(by);
        c.x = coord_t'(cx);
        c.y = coord_t'(cy);
        row = coord_t'(sy);
        word = '0;
        word[0*CB +: CB] = a.x;
        word[1*CB +: CB] = a.y;
        word[2*CB +: CB] = b.x;
        word[3*CB +: CB] = b.y;
        word[4*CB +: CB] = c.x;
        word[5*CB +: CB] = c.y;
        word[6*CB +: CB] = row;
        while (!calm && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_spans.push_back(predict_span(a, b, c, row));
    endtask

    task automatic test_extremes();
        send_span(-2048, 2047, 2047, -2048, -2048, -2048, 0);
        send_span(-2048, 2047, 2047, -2048, -2048, -2048, 2047);
        send_span(-2048, 2047, 2047, -2048, -2048, -2048, -2048);
        send_span(2047, 2047, 2047, 2047, 2047, 2047, 2047);
        send_span(-2048, -2048, -2048, -2048, -2048, -2048, -2048);
        send_span(2047, -2048, -2048, 2047, 2047, 0, 1);
        send_span(-2048, -2048, 2047, 2047, -2048, 2047, -1);
    endtask

    task automatic test_flat_edges_and_ties();
        // flat long edge
        send_span(-5, 7, 9, 7, 3, 7, 7);
        // flat upper edge, row on it in the first two
        send_span(0, 5, 10, 5, 20, -5, 5);
        send_span(10, 5, 0, 5, 20, -5, 5);
        send_span(20, -5, 10, 5, 0, 5, 0);
        // flat lower edge, row on it
        send_span(30, 40, -7, -3, 11, -3, -3);
        send_span(30, 40, 11, -3, -7, -3, -3);
    endtask

    task automatic test_outside_and_bounds();
        send_span(0, 10, 20, 0, -20, -10, 11);
        send_span(0, 10, 20, 0, -20, -10, -11);
        send_span(0, 10, 20, 0, -20, -10, 10);
        send_span(0, 10, 20, 0, -20, -10, -10);
        send_span(-5, 7, 9, 7, 3, 7, 8);
    endtask

    task automatic test_truncation();
        send_span(0, 10, 7, 0, 7, 0, 5);
        send_span(0, 10, -7, 0, -7, 0, 5);
        send_span(0, 10, 3, 9, -7, 0, 4);
        send_span(-100, -30, 100, 3, 1, -1, -7);
    endtask

    task automatic test_random_spans(input int count);
        int xs[3];
        int ys[3];
        int spread;
        int base_x;
        int base_y;
        int lo;
        int hi;
        int row;
        int mode;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= count / 2) && (n < count / 2 + 300);
            mode = $urandom_range(9);
            if (mode < 3)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    xs[i] = int'($urandom_range(4095)) - 2048;
                    ys[i] = int'($urandom_range(4095)) - 2048;
                end
            end
            else
            begin
                spread = (mode < 6) ? int'($urandom_range(63, 1)) : int'($urandom_range(1023, 64));
                base_x = int'($urandom_range(4095 - spread)) - 2048;
                base_y = int'($urandom_range(4095 - spread)) - 2048;
                for (int i = 0; i < 3; i++)
                begin
                    xs[i] = base_x + int'($urandom_range(spread));
                    ys[i] = base_y + int'($urandom_range(spread));
                end
            end
            if ($urandom_range(3) == 0)
                ys[$urandom_range(2)] = ys[$urandom_range(2)];
            lo = ys[0];
            hi = ys[0];
            for (int i = 1; i < 3; i++)
            begin
                if (ys[i] < lo)
                    lo = ys[i];
                if (ys[i] > hi)
                    hi = ys[i];
            end
            pick = $urandom_range(99);
            if (pick < 70)
                row = lo + int'($urandom_range(hi - lo));
            else if (pick < 85)
                row = ys[$urandom_range(2)];
            else
                row = int'($urandom_range(4095)) - 2048;
            send_span(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], row);
        end
        calm = 1'b0;
    endtask

    // sink side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 24);
    end

    // result checker
    always @(posedge clk)
    begin
        span_t want;
        coord_t got_long;
        coord_t got_short;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_long = m_axis_tdata[0 +: CB];
            got_short = m_axis_tdata[CB +: CB];
            if (expected_spans.size() == 0)
                report_mismatch("unexpected item, long_edge_x", got_long, 0);
            else
            begin
                want = expected_spans.pop_front();
                if (got_long !== want.long_x)
                    report_mismatch("long_edge_x", got_long, want.long_x);
                if (got_short !== want.short_x)
                    report_mismatch("short_edge_x", got_short, want.short_x);
                if (m_axis_tuser !== want.in_range)
                    report_mismatch("in_range", {31'b0, m_axis_tuser}, {31'b0, want.in_range});
            end
        end
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_flat_edges_and_ties();
        test_outside_and_bounds();
        test_truncation();
        test_random_spans(1830);
        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (expected_spans.size() != 0)
            report_mismatch("items still pending", 0, expected_spans.size());
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* triangle_scanline_span.f */
+incdir+hdl
hdl/tss_pkg.sv
hdl/tss_divider.sv
hdl/triangle_scanline_span.sv
bench/triangle_scanline_span_tb.sv
